// ===== hw/rtl/xpf_pkg.sv =====
// xpf_pkg: shared types and constants for the xor pair fec / retransmit engine
// used by xpf_ctrl, xpf_dp and the top level; no dependencies
package xpf_pkg;

  // field widths fixed by the interface
  localparam int SEQ_W  = 32;
  localparam int WI_W   = 5;
  localparam int DATA_W = 64;
  localparam int KIND_W = 2;

  // parameter defaults
  localparam int HISTORY_FRAMES_DEF  = 64;
  localparam int WORDS_PER_FRAME_DEF = 20;

  // parity beats carry the sequence with the top bit set
  localparam logic [SEQ_W-1:0] PARITY_FLAG = 32'h8000_0000;

  // result kind codes
  typedef enum logic [KIND_W-1:0] {
    KIND_FWD  = 2'd0,
    KIND_PAR  = 2'd1,
    KIND_RETX = 2'd2
  } kind_t;

  // commands from controller to datapath
  typedef struct packed {
    logic  capture;
    logic  clr_step;
    logic  upd;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  out_load;
    kind_t out_kind;
    logic  out_last;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_nack;
    logic wi_oor;
    logic seq_odd;
    logic hit;
    logic cnt_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/xpf_ctrl.sv =====
// xpf_ctrl: sequencing state machine of the fec / retransmit engine
// depends on xpf_pkg; drives xpf_dp through dp_cmd_t, reads dp_sts_t
module xpf_ctrl import xpf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_MOD1   = 10'b00_0000_0100,
    S_MOD2   = 10'b00_0000_1000,
    S_MOD3   = 10'b00_0001_0000,
    S_LOOK   = 10'b00_0010_0000,
    S_DECIDE = 10'b00_0100_0000,
    S_PARITY = 10'b00_1000_0000,
    S_RD     = 10'b01_0000_0000,
    S_EMIT   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.out_kind = KIND_FWD;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MOD1;
        end
      end
      S_MOD1: begin
        // out of range word: forward only, nothing stored
        if (!sts.is_nack && sts.wi_oor) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_FWD;
            cmd.out_last = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          state_next = S_MOD2;
        end
      end
      S_MOD2: state_next = S_MOD3;
      S_MOD3: state_next = S_LOOK;
      S_LOOK: state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.is_nack) begin
          if (sts.hit) begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_RD;
          end else begin
            state_next = S_IDLE;
          end
        end else if (sts.out_free) begin
          cmd.upd      = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_FWD;
          cmd.out_last = !sts.seq_odd;
          state_next   = sts.seq_odd ? S_PARITY : S_IDLE;
        end
      end
      S_PARITY: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_PAR;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RD: state_next = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_RETX;
          cmd.out_last = sts.cnt_last;
          cmd.cnt_inc  = 1'b1;
          state_next   = sts.cnt_last ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/xpf_dp.sv =====
// xpf_dp: datapath of the fec / retransmit engine: slot reduction, history
// and tag memories, even partner store, replay counter and output register; uses xpf_pkg
module xpf_dp import xpf_pkg::*; #(
  parameter int HISTORY_FRAMES  = HISTORY_FRAMES_DEF,
  parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_type,
  input  logic [SEQ_W-1:0]  seq,
  input  logic [WI_W-1:0]   word_index,
  input  logic [DATA_W-1:0] data,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [KIND_W-1:0] kind,
  output logic [SEQ_W-1:0]  seq_out,
  output logic [WI_W-1:0]   word_out,
  output logic [DATA_W-1:0] payload_out,
  output logic              last
);

  localparam int SLOT_W  = $clog2(HISTORY_FRAMES);
  localparam int SHIFT   = 31 + SLOT_W;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(HISTORY_FRAMES);
  localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
  localparam int ENTRIES = HISTORY_FRAMES * WORDS_PER_FRAME;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int CNT_W   = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_FRAMES - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(WORDS_PER_FRAME - 1);
  localparam logic [SEQ_W-1:0]  FRAMES_W  = SEQ_W'(HISTORY_FRAMES);

  // captured input beat
  logic              req_q;
  logic [SEQ_W-1:0]  seq_q;
  logic [WI_W-1:0]   wi_q;
  logic [DATA_W-1:0] data_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_type;
      seq_q  <= seq;
      wi_q   <= word_index;
      data_q <= data;
    end
  end

  // slot = seq mod frames: reciprocal multiply, back multiply, one correction
  logic [63:0]       prod_q;
  logic [SEQ_W-1:0]  quot;
  logic [SEQ_W-1:0]  qh_q;
  logic [SEQ_W-1:0]  rem;
  logic [SLOT_W-1:0] slot_q;

  assign quot = SEQ_W'(prod_q >> SHIFT);
  assign rem  = seq_q - qh_q;

  always_ff @(posedge clk) begin
    prod_q <= 64'(seq_q) * 64'(RECIP);
    qh_q   <= quot * FRAMES_W;
    slot_q <= (rem >= FRAMES_W) ? SLOT_W'(rem - FRAMES_W) : SLOT_W'(rem);
  end

  // clearing pass counter over the tag memory
  logic [SLOT_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // tag memory, valid bit on top
  logic [SEQ_W:0] tag_mem [HISTORY_FRAMES];
  logic [SEQ_W:0] tag_rd;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      tag_mem[clr_cnt] <= '0;
    end else if (cmd.upd) begin
      tag_mem[slot_q] <= {1'b1, seq_q};
    end
    tag_rd <= tag_mem[slot_q];
  end

  // frame base address in the word memory
  logic [ADDR_W-1:0] base_q;

  always_ff @(posedge clk) begin
    base_q <= ADDR_W'(slot_q) * ADDR_W'(WORDS_PER_FRAME);
  end

  // replay counter
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // history word memory
  logic [DATA_W-1:0] word_mem [ENTRIES];
  logic [DATA_W-1:0] word_rd;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      word_mem[base_q + ADDR_W'(wi_q)] <= data_q;
    end
    word_rd <= word_mem[base_q + ADDR_W'(cnt_q)];
  end

  // even frame partner store, zero until written
  logic [DATA_W-1:0]          even_mem [WORDS_PER_FRAME];
  logic [WORDS_PER_FRAME-1:0] even_vld;
  logic [DATA_W-1:0]          even_rd;
  logic                       even_ok;
  logic [CNT_W-1:0]           ev_idx;
  logic [DATA_W-1:0]          partner;

  assign ev_idx  = CNT_W'(wi_q);
  assign partner = even_ok ? even_rd : '0;

  always_ff @(posedge clk) begin
    if (cmd.upd && !seq_q[0]) begin
      even_mem[ev_idx] <= data_q;
    end
    even_rd <= even_mem[ev_idx];
    even_ok <= even_vld[ev_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      even_vld <= '0;
    end else if (cmd.upd && !seq_q[0]) begin
      even_vld[ev_idx] <= 1'b1;
    end
  end

  // output register
  logic              out_valid_q;
  kind_t             kind_q;
  logic [SEQ_W-1:0]  seq_out_q;
  logic [WI_W-1:0]   word_out_q;
  logic [DATA_W-1:0] payload_q;
  logic              last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind_q <= cmd.out_kind;
      last_q <= cmd.out_last;
      unique case (cmd.out_kind)
        KIND_FWD: begin
          seq_out_q  <= seq_q;
          word_out_q <= wi_q;
          payload_q  <= data_q;
        end
        KIND_PAR: begin
          seq_out_q  <= seq_q | PARITY_FLAG;
          word_out_q <= wi_q;
          payload_q  <= partner ^ data_q;
        end
        KIND_RETX: begin
          seq_out_q  <= seq_q;
          word_out_q <= WI_W'(cnt_q);
          payload_q  <= word_rd;
        end
        default: begin
          seq_out_q  <= seq_q;
          word_out_q <= wi_q;
          payload_q  <= data_q;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_q;
  assign kind        = kind_q;
  assign seq_out     = seq_out_q;
  assign word_out    = word_out_q;
  assign payload_out = payload_q;
  assign last        = last_q;

  // status
  assign sts.clr_last = (clr_cnt == SLOT_LAST);
  assign sts.is_nack  = req_q;
  assign sts.wi_oor   = (32'(wi_q) >= 32'(WORDS_PER_FRAME));
  assign sts.seq_odd  = seq_q[0];
  assign sts.hit      = tag_rd[SEQ_W] && (tag_rd[SEQ_W-1:0] == seq_q);
  assign sts.cnt_last = (cnt_q == CNT_LAST);
  assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ===== hw/rtl/xor_pair_fec_with_retransmit_buffer_unit.sv =====
// xor pair fec / retransmit engine top level: xpf_ctrl plus xpf_dp; uses xpf_pkg
// each beat: capture, slot reduction (prod_q, qh_q, slot_q), tag read, then results;
// no new beat is taken until its last result is loaded; payload word: forward beat,
// then a parity beat for odd frames; an out of range word index is forwarded directly
// nack hit: each replayed word takes a word memory read, then an output load
// reset: clears control state, then sweeps the tag memory, one slot per cycle over
// all HISTORY_FRAMES slots, with in_ready low
module xor_pair_fec_with_retransmit_buffer_unit import xpf_pkg::*; #(
  parameter int HISTORY_FRAMES  = HISTORY_FRAMES_DEF,
  parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [SEQ_W-1:0]  seq,
  input  logic [WI_W-1:0]   word_index,
  input  logic [DATA_W-1:0] data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] kind,
  output logic [SEQ_W-1:0]  seq_out,
  output logic [WI_W-1:0]   word_out,
  output logic [DATA_W-1:0] payload_out,
  output logic              last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller
  xpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  xpf_dp #(
    .HISTORY_FRAMES  (HISTORY_FRAMES),
    .WORDS_PER_FRAME (WORDS_PER_FRAME)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .seq         (seq),
    .word_index  (word_index),
    .data        (data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .kind        (kind),
    .seq_out     (seq_out),
    .word_out    (word_out),
    .payload_out (payload_out),
    .last        (last)
  );

  // a waiting result beat is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output beat overwritten while stalled");

  // a replay beat that is not last keeps the block busy
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_RETX && !last) |-> !in_ready)
    else $error("input taken in the middle of a replay");

  // parity beat follows a forward beat of the same word
  assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_kind == KIND_PAR) |->
      (out_valid && kind == KIND_FWD && !last) || $past(cmd.out_load))
    else $error("parity beat without its forward beat");

endmodule
